// ===== rtl/core/spwr_pkg.sv =====
// Shared constants and register indexes of the splat weight paint block.
`default_nettype none

package spwr_pkg;

    // Default number of splat layers per vertex.
    localparam int SPLAT_LAYERS_DEF = 4;

    // Widths of the configuration channel.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Widths of the item fields.
    localparam int OFFSET_W = 16;
    localparam int WEIGHT_W = 8;
    localparam int RADIUS_W = 15;
    localparam int STRENGTH_W = 16;
    localparam int LAYER_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_RADIUS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_STRENGTH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_LAYER    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_MODE     = 4'd3;

endpackage

`default_nettype wire

// ===== rtl/core/spwr_if.sv =====
// Channel interfaces of the splat weight paint block: vertex items, results, configuration.
`default_nettype none

interface spwr_item_if
    import spwr_pkg::*;
#(
    parameter int SPLAT_LAYERS = SPLAT_LAYERS_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [OFFSET_W-1:0]         offset_x;
    logic signed [OFFSET_W-1:0]         offset_z;
    logic [SPLAT_LAYERS*WEIGHT_W-1:0]   in_weight;

    modport source (output valid, output offset_x, output offset_z, output in_weight,
                    input ready);
    modport sink   (input valid, input offset_x, input offset_z, input in_weight,
                    output ready);
endinterface

interface spwr_result_if
    import spwr_pkg::*;
#(
    parameter int SPLAT_LAYERS = SPLAT_LAYERS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [SPLAT_LAYERS*WEIGHT_W-1:0]   out_weight;
    logic                               changed;

    modport source (output valid, output out_weight, output changed, input ready);
    modport sink   (input valid, input out_weight, input changed, output ready);
endinterface

interface spwr_cfg_if
    import spwr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/splat_weight_paint_renormalize.sv =====
// Splat weight paint and renormalise: top level, a 30-stage pipeline.
//
// Channels: item_in takes one vertex per item (offset from the brush centre
// and the splat weights), result_out gives the new weights and a changed
// flag, one result item per vertex item, in order. cfg writes the brush
// radius, strength, painted layer and erase mode; it is always ready.
// The user must write it only while the pipeline is empty; the block
// itself does not enforce this.
// Throughput: one item per cycle while the receiver takes results.
// Every stage holds a valid bit; a stage takes a new item whenever it is
// empty or its item moves on, so bubbles close up and a waiting result
// does not stop the stages behind it from filling.
// The depth is set by the square root (two root bits per stage, eight
// stages), the falloff divider (two quotient bits per stage after the first,
// nine stages) and the renormalising dividers (two bits per stage, four stages).
// Reset clears all valid bits and the configuration registers; the brush
// is then disabled and vertices pass through unchanged.
// When the receiver stalls, the result is held in the output stage and
// items queue up in the stages behind it; none is lost or repeated.
`default_nettype none

module splat_weight_paint_renormalize
    import spwr_pkg::*;
#(
    parameter int SPLAT_LAYERS = SPLAT_LAYERS_DEF
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    spwr_cfg_if.sink           cfg,
    spwr_item_if.sink          item_in,
    spwr_result_if.source      result_out
);

    localparam int L    = SPLAT_LAYERS;
    localparam int LW   = (L > 1) ? $clog2(L) : 1;
    localparam int SW   = $clog2(L * 255 + 1);
    localparam int WW   = L * WEIGHT_W;

    // Stage map.
    localparam int NSQ    = 8;
    localparam int NDV    = 9;
    localparam int NLN    = 4;
    localparam int ST_SQ  = 0;
    localparam int ST_D2  = ST_SQ + 1;
    localparam int ST_RT0 = ST_D2 + 1;
    localparam int ST_DV0 = ST_RT0 + NSQ;
    localparam int ST_F2  = ST_DV0 + NDV;
    localparam int ST_WT  = ST_F2 + 1;
    localparam int ST_P   = ST_WT + 1;
    localparam int ST_DL  = ST_P + 1;
    localparam int ST_MIX = ST_DL + 1;
    localparam int ST_NUM = ST_MIX + 1;
    localparam int ST_LN0 = ST_NUM + 1;
    localparam int ST_OUT = ST_LN0 + NLN;
    localparam int NS     = ST_OUT + 1;

    typedef struct packed {
        logic [31:0] d;
        logic [19:0] rem;
        logic [15:0] root;
    } sq_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [16:0] q;
    } dv_t;

    typedef struct packed {
        logic [WW-1:0]          w;
        logic [WEIGHT_W-1:0]    nv;
        logic [LW-1:0]          lyr;
        logic                   chg;
        logic                   scale;
        logic [SW-1:0]          oth;
    } ctl_t;

    // One restoring square root step: one root bit.
    function automatic sq_t sqrt_step(input sq_t s);
        sq_t         r;
        logic [19:0] sh;
        logic [19:0] trial;
        sh    = {s.rem[17:0], s.d[31:30]};
        trial = {2'b00, s.root, 2'b01};
        if (sh >= trial)
        begin
            r.rem  = sh - trial;
            r.root = {s.root[14:0], 1'b1};
        end
        else
        begin
            r.rem  = sh;
            r.root = {s.root[14:0], 1'b0};
        end
        r.d = {s.d[29:0], 2'b00};
        return r;
    endfunction

    // One restoring division step of the falloff quotient.
    function automatic dv_t div_step(input dv_t s, input logic nbit,
                                     input logic [RADIUS_W-1:0] rad);
        dv_t         r;
        logic [15:0] sh;
        sh = {s.rem[14:0], nbit};
        if (sh >= {1'b0, rad})
        begin
            r.rem = sh - {1'b0, rad};
            r.q   = {s.q[15:0], 1'b1};
        end
        else
        begin
            r.rem = sh;
            r.q   = {s.q[15:0], 1'b0};
        end
        return r;
    endfunction

    // Configuration registers.
    logic [RADIUS_W-1:0]   radius_reg;
    logic [STRENGTH_W-1:0] strength_reg;
    logic [LAYER_W-1:0]    layer_reg;
    logic                  erase_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= '0;
            strength_reg <= '0;
            layer_reg    <= '0;
            erase_reg    <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_BRUSH_RADIUS:   radius_reg   <= cfg.data[RADIUS_W-1:0];
                REG_BRUSH_STRENGTH: strength_reg <= cfg.data[STRENGTH_W-1:0];
                REG_PAINT_LAYER:    layer_reg    <= cfg.data[LAYER_W-1:0];
                REG_ERASE_MODE:     erase_reg    <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Valid bits and the stage advance chain.
    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || result_out.ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign item_in.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= item_in.valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Weights travel alongside until the mixing stage.
    logic [WW-1:0] w_pipe_reg [ST_MIX];

    always_ff @(posedge clk)
    begin
        if (adv[0])
            w_pipe_reg[0] <= item_in.in_weight;
        for (int k = 1; k < ST_MIX; k++)
            if (adv[k])
                w_pipe_reg[k] <= w_pipe_reg[k-1];
    end

    // Squares of the offsets.
    logic signed [31:0] xsq;
    logic signed [31:0] zsq;
    logic [31:0]        xx_reg;
    logic [31:0]        zz_reg;
    logic [31:0]        d2_reg;

    assign xsq = item_in.offset_x * item_in.offset_x;
    assign zsq = item_in.offset_z * item_in.offset_z;

    always_ff @(posedge clk)
    begin
        if (adv[ST_SQ])
        begin
            xx_reg <= $unsigned(xsq);
            zz_reg <= $unsigned(zsq);
        end
        if (adv[ST_D2])
            d2_reg <= xx_reg + zz_reg;
    end

    // Square root, two root bits per stage.
    sq_t sq_reg [NSQ];
    sq_t sq_in  [NSQ];
    sq_t sq_out [NSQ];

    always_comb
    begin
        for (int j = 0; j < NSQ; j++)
        begin
            if (j == 0)
            begin
                sq_in[j].d    = d2_reg;
                sq_in[j].rem  = '0;
                sq_in[j].root = '0;
            end
            else
                sq_in[j] = sq_reg[j-1];
            sq_out[j] = sqrt_step(sqrt_step(sq_in[j]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NSQ; j++)
            if (adv[ST_RT0+j])
                sq_reg[j] <= sq_out[j];
    end

    // Falloff quotient distance * 65536 / radius, two bits per stage after the first.
    logic [15:0] root_dist;
    logic        act_in;
    dv_t         dv_init;
    dv_t         dv_reg [NDV];
    dv_t         dv_out [NDV];
    logic        dv_act_reg [NDV];

    assign root_dist = sq_reg[NSQ-1].root;
    assign act_in    = (radius_reg != '0) && (strength_reg != '0)
                       && (root_dist <= {1'b0, radius_reg});

    always_comb
    begin
        dv_init.rem = {1'b0, root_dist[15:1]};
        dv_init.q   = '0;
        dv_out[0]   = div_step(dv_init, root_dist[0], radius_reg);
        for (int j = 1; j < NDV; j++)
            dv_out[j] = div_step(div_step(dv_reg[j-1], 1'b0, radius_reg),
                                 1'b0, radius_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_DV0])
        begin
            dv_reg[0]     <= dv_out[0];
            dv_act_reg[0] <= act_in;
        end
        for (int j = 1; j < NDV; j++)
            if (adv[ST_DV0+j])
            begin
                dv_reg[j]     <= dv_out[j];
                dv_act_reg[j] <= dv_act_reg[j-1];
            end
    end

    // Smoothstep weight and paint delta.
    logic [16:0] f;
    logic [33:0] f2_prod;
    logic [16:0] f_reg;
    logic [16:0] f2_reg;
    logic        act_f2_reg;
    logic [17:0] sm_term;
    logic [34:0] wt_prod;
    logic [16:0] wt_reg;
    logic        act_wt_reg;
    logic [32:0] p_reg;
    logic        act_p_reg;
    logic [31:0] p255;
    logic [WEIGHT_W-1:0] delta_reg;
    logic        act_dl_reg;

    assign f       = 17'h10000 - dv_reg[NDV-1].q;
    assign f2_prod = f * f;
    assign sm_term = 18'h30000 - {f_reg, 1'b0};
    assign wt_prod = f2_reg * sm_term;
    assign p255    = {p_reg[23:0], 8'h00} - {8'h00, p_reg[23:0]};

    always_ff @(posedge clk)
    begin
        if (adv[ST_F2])
        begin
            f_reg      <= f;
            f2_reg     <= f2_prod[32:16];
            act_f2_reg <= dv_act_reg[NDV-1];
        end
        if (adv[ST_WT])
        begin
            wt_reg     <= wt_prod[32:16];
            act_wt_reg <= act_f2_reg;
        end
        if (adv[ST_P])
        begin
            p_reg     <= strength_reg * wt_reg;
            act_p_reg <= act_wt_reg;
        end
        if (adv[ST_DL])
        begin
            delta_reg  <= (p_reg[32:24] != '0) ? 8'hFF : p255[31:24];
            act_dl_reg <= act_p_reg;
        end
    end

    // Layer update and renormalisation decision.
    logic [LW-1:0]       lyr;
    logic [WW-1:0]       w_mix;
    logic [WEIGHT_W-1:0] old_w;
    logic [WEIGHT_W-1:0] nv;
    logic [8:0]          add_sum;
    logic [SW-1:0]       oth;
    logic [WEIGHT_W-1:0] target;
    logic                chg;
    logic                scale;
    ctl_t                ctl_mix;

    always_comb
    begin
        w_mix = w_pipe_reg[ST_MIX-1];
        if (32'(layer_reg) > L - 1)
            lyr = LW'(L - 1);
        else
            lyr = LW'(layer_reg);
        old_w   = w_mix[lyr*WEIGHT_W +: WEIGHT_W];
        add_sum = {1'b0, old_w} + {1'b0, delta_reg};
        oth     = '0;
        for (int i = 0; i < L; i++)
            if (LW'(i) != lyr)
                oth = oth + SW'(w_mix[i*WEIGHT_W +: WEIGHT_W]);
        if (erase_reg)
            nv = (old_w > delta_reg) ? old_w - delta_reg : '0;
        else
            nv = add_sum[8] ? 8'hFF : add_sum[7:0];
        target = 8'hFF - nv;
        chg    = act_dl_reg && (delta_reg != '0) && (nv != old_w);
        scale  = chg && !erase_reg && (oth > SW'(target));
        ctl_mix.w     = w_mix;
        ctl_mix.nv    = nv;
        ctl_mix.lyr   = lyr;
        ctl_mix.chg   = chg;
        ctl_mix.scale = scale;
        ctl_mix.oth   = oth;
    end

    ctl_t                mx_ctl_reg;
    logic [WEIGHT_W-1:0] mx_tgt_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_MIX])
        begin
            mx_ctl_reg <= ctl_mix;
            mx_tgt_reg <= target;
        end
    end

    // Numerators weight * target per lane.
    ctl_t        ctl_reg [NLN+1];
    logic [15:0] nm_reg  [L];

    always_ff @(posedge clk)
    begin
        if (adv[ST_NUM])
        begin
            ctl_reg[0] <= mx_ctl_reg;
            for (int i = 0; i < L; i++)
                nm_reg[i] <= mx_ctl_reg.w[i*WEIGHT_W +: WEIGHT_W] * mx_tgt_reg;
        end
    end

    // Renormalising dividers, two quotient bits per stage in each lane.
    logic [SW-1:0]       ln_rem_reg [NLN][L];
    logic [7:0]          ln_n_reg   [NLN][L];
    logic [7:0]          ln_q_reg   [NLN][L];
    logic [SW-1:0]       ln_rem_nx  [NLN][L];
    logic [7:0]          ln_n_nx    [NLN][L];
    logic [7:0]          ln_q_nx    [NLN][L];

    always_comb
    begin
        logic [SW:0]   sh;
        logic [SW-1:0] rem;
        logic [7:0]    n;
        logic [7:0]    q;
        logic [SW-1:0] dvs;
        for (int j = 0; j < NLN; j++)
        begin
            dvs = ctl_reg[j].oth;
            for (int i = 0; i < L; i++)
            begin
                if (j == 0)
                begin
                    rem = SW'(nm_reg[i][15:8]);
                    n   = nm_reg[i][7:0];
                    q   = '0;
                end
                else
                begin
                    rem = ln_rem_reg[j-1][i];
                    n   = ln_n_reg[j-1][i];
                    q   = ln_q_reg[j-1][i];
                end
                for (int s = 0; s < 2; s++)
                begin
                    sh = {rem, n[7]};
                    if (sh >= {1'b0, dvs})
                    begin
                        sh  = sh - {1'b0, dvs};
                        q   = {q[6:0], 1'b1};
                    end
                    else
                        q   = {q[6:0], 1'b0};
                    rem = sh[SW-1:0];
                    n   = {n[6:0], 1'b0};
                end
                ln_rem_nx[j][i] = rem;
                ln_n_nx[j][i]   = n;
                ln_q_nx[j][i]   = q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NLN; j++)
            if (adv[ST_LN0+j])
            begin
                ctl_reg[j+1] <= ctl_reg[j];
                for (int i = 0; i < L; i++)
                begin
                    ln_rem_reg[j][i] <= ln_rem_nx[j][i];
                    ln_n_reg[j][i]   <= ln_n_nx[j][i];
                    ln_q_reg[j][i]   <= ln_q_nx[j][i];
                end
            end
    end

    // Output stage: pick painted, scaled or unchanged weight per lane.
    logic [WW-1:0] out_w;
    logic [WW-1:0] out_w_reg;
    logic          out_chg_reg;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            if (ctl_reg[NLN].chg && (ctl_reg[NLN].lyr == LW'(i)))
                out_w[i*WEIGHT_W +: WEIGHT_W] = ctl_reg[NLN].nv;
            else if (ctl_reg[NLN].scale)
                out_w[i*WEIGHT_W +: WEIGHT_W] = ln_q_reg[NLN-1][i];
            else
                out_w[i*WEIGHT_W +: WEIGHT_W] = ctl_reg[NLN].w[i*WEIGHT_W +: WEIGHT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            out_w_reg   <= out_w;
            out_chg_reg <= ctl_reg[NLN].chg;
        end
    end

    assign result_out.valid      = v_reg[NS-1];
    assign result_out.out_weight = out_w_reg;
    assign result_out.changed    = out_chg_reg;

endmodule

`default_nettype wire
